FILE: hdl/assert_macros.svh
// Assertion macros shared by the slice index generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/gsri_pkg.sv
// Package with types and constants of the grouped slice row index generator.
`default_nettype none

package gsri_pkg;

  // Field and register widths
  localparam int unsigned ROW_W     = 31;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CALC_W    = 34;
  localparam int unsigned COUNT_W   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ABSENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_STOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ABSENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ROWS   = 3'd5;

  // Walk direction picked by the sign of the step
  typedef enum logic [1:0] {
    MODE_FWD,
    MODE_BWD,
    MODE_ZERO
  } walk_mode_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_ADJ,
    ST_BASE,
    ST_PROBE,
    ST_CHECK,
    ST_RUN
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic sel;
    logic adj;
    logic base;
    logic probe;
    logic check;
    logic emit;
  } gsri_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic first_ok;
    logic last;
    logic slot_free;
  } gsri_status_t;

endpackage

`default_nettype wire

FILE: hdl/gsri_in_if.sv
// Input channel interface: one group per transfer.
`default_nettype none

interface gsri_in_if
  import gsri_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] group_begin;
  logic [ROW_W-1:0] group_end;

  modport source (output valid, output group_begin, output group_end, input ready);
  modport sink   (input valid, input group_begin, input group_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/gsri_out_if.sv
// Output channel interface: one selected row index per transfer.
`default_nettype none

interface gsri_out_if
  import gsri_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [ROW_W-1:0] emitted_total;
  logic [ROW_W-1:0] group_ordinal;
  logic             last;
  logic             truncated;

  modport source (output valid, output row_index, output emitted_total,
                  output group_ordinal, output last, output truncated, input ready);
  modport sink   (input valid, input row_index, input emitted_total,
                  input group_ordinal, input last, input truncated, output ready);
endinterface

`default_nettype wire

FILE: hdl/gsri_ctrl.sv
// Controller state machine sequencing slice setup and the index walk.
`default_nettype none

`include "assert_macros.svh"

module gsri_ctrl
  import gsri_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire gsri_status_t status_i,
  output gsri_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  // Advance through setup, then walk until the last index is loaded for output; an empty group skips the walk
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SEL;
      ST_SEL:   state_d = ST_ADJ;
      ST_ADJ:   state_d = ST_BASE;
      ST_BASE:  state_d = ST_PROBE;
      ST_PROBE: state_d = ST_CHECK;
      ST_CHECK: state_d = status_i.first_ok ? ST_RUN : ST_IDLE;
      ST_RUN: begin
        if (status_i.slot_free && status_i.last) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Decode commands from the state
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o       = '0;
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sel   = (state_q == ST_SEL);
    cmd_o.adj   = (state_q == ST_ADJ);
    cmd_o.base  = (state_q == ST_BASE);
    cmd_o.probe = (state_q == ST_PROBE);
    cmd_o.check = (state_q == ST_CHECK);
    cmd_o.emit  = (state_q == ST_RUN) && status_i.slot_free;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_load_starts_setup, cmd_o.load |=> state_q == ST_SEL, "load not followed by setup")
  `ASSERT_CLK(a_last_ends_walk, cmd_o.emit && status_i.last |=> state_q == ST_IDLE, "walk did not end")
  `ASSERT_CLK(a_empty_skips_walk, state_q == ST_CHECK && !status_i.first_ok |=> state_q == ST_IDLE, "empty group walked")

endmodule

`default_nettype wire

FILE: hdl/gsri_datapath.sv
// Datapath: configuration registers, slice bound arithmetic, walk and output register.
`default_nettype none

`include "assert_macros.svh"

module gsri_datapath
  import gsri_pkg::*;
#(
  parameter int unsigned MAX_RUN  = 64,
  parameter int unsigned ROW_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [ROW_W-1:0]     group_begin_i,
  input  wire logic [ROW_W-1:0]     group_end_i,
  input  wire gsri_cmd_t            cmd_i,
  output gsri_status_t              status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [ROW_W-1:0]          row_index_o,
  output logic [ROW_W-1:0]          emitted_total_o,
  output logic [ROW_W-1:0]          group_ordinal_o,
  output logic                      last_o,
  output logic                      truncated_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_RUN + 1);
  localparam int unsigned PROBE_W = CFG_W + CNT_W + 2;
  localparam logic [ROW_W-1:0]          RowMask    = {ROW_W{1'b1}} >> (ROW_W - ROW_BITS);
  localparam logic [CNT_W-1:0]          RunMax     = CNT_W'(MAX_RUN);
  localparam logic [CNT_W-1:0]          RunLastIdx = CNT_W'(MAX_RUN - 1);
  localparam logic signed [CFG_W-1:0]   RunMaxS    = CFG_W'(MAX_RUN);
  localparam logic signed [PROBE_W-1:0] RunMaxP    = PROBE_W'(MAX_RUN);

  // Configuration registers
  logic signed [CFG_W-1:0] slice_start_q, slice_stop_q, step_size_q;
  logic                    start_absent_q, stop_absent_q;
  logic [ROW_W-1:0]        total_rows_q;

  // Setup registers
  logic [ROW_W-1:0]          begin_q, n_q;
  logic signed [CALC_W-1:0]  s0_q, t0_q, s1_q, t1_q, cur_q, stop_q;
  logic signed [PROBE_W-1:0] prod_q, probe_q;
  logic                      zero_ok_q, zero_more_q, first_ok_q, more_q;
  logic [CNT_W-1:0]          reps_eff_q, run_cnt_q;

  // Running counters
  logic [COUNT_W-1:0] idx_count_q, nonempty_q;

  // Output register
  logic             out_valid_q;
  logic [ROW_W-1:0] row_index_q, emitted_total_q, group_ordinal_q;
  logic             last_q, truncated_q;

  walk_mode_e                mode;
  logic [ROW_W-1:0]          bm, em, n_d;
  logic signed [CALC_W-1:0]  n_s, begin_s, ss, sp, step_c, total_s;
  logic signed [CALC_W-1:0]  s0_d, t0_d, s1_d, t1_d, s_wrap, t_wrap, nxt;
  logic signed [PROBE_W-1:0] step_p, prod_d, probe_d, stop_p;
  logic                      zero_ok_d, reps_pos, zero_more_d, first_ok_d, more_d;
  logic                      next_ok, last_w, slot_free;
  logic [CNT_W-1:0]          reps_eff_d;
  logic [COUNT_W-1:0]        idx_count_d;

  // Store configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_start_q  <= '0;
      start_absent_q <= 1'b1;
      slice_stop_q   <= '0;
      stop_absent_q  <= 1'b1;
      step_size_q    <= CFG_W'(1);
      total_rows_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLICE_START:  slice_start_q  <= cfg_data_i;
        CFG_START_ABSENT: start_absent_q <= cfg_data_i[0];
        CFG_SLICE_STOP:   slice_stop_q   <= cfg_data_i;
        CFG_STOP_ABSENT:  stop_absent_q  <= cfg_data_i[0];
        CFG_STEP_SIZE:    step_size_q    <= cfg_data_i;
        CFG_TOTAL_ROWS:   total_rows_q   <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode walk direction and extend operands
  always_comb begin
    if (step_size_q[CFG_W-1]) begin
      mode = MODE_BWD;
    end else if (step_size_q == '0) begin
      mode = MODE_ZERO;
    end else begin
      mode = MODE_FWD;
    end
    n_s     = $signed(CALC_W'(n_q));
    begin_s = $signed(CALC_W'(begin_q));
    ss      = CALC_W'(slice_start_q);
    sp      = CALC_W'(slice_stop_q);
    step_c  = CALC_W'(step_size_q);
    step_p  = PROBE_W'(step_size_q);
    total_s = $signed(CALC_W'(total_rows_q & RowMask));
  end

  // Mask the group bounds and take its size
  always_comb begin
    bm  = group_begin_i & RowMask;
    em  = group_end_i & RowMask;
    n_d = (em < bm) ? '0 : em - bm;
  end

  // Pick raw start and stop, scale the step for the truncation probe
  always_comb begin
    s0_d = start_absent_q ? '0 : ss;
    t0_d = sp;
    case (mode)
      MODE_FWD: begin
        if (stop_absent_q) t0_d = total_s;
      end
      MODE_BWD: begin
        if (start_absent_q || (ss >= n_s)) s0_d = n_s - CALC_W'(1);
      end
      default: ;
    endcase
    prod_d = step_p * RunMaxP;
  end

  // Count negative bounds from the group end and clamp them; work out the zero-step repeat count
  always_comb begin
    s_wrap = s0_q + n_s;
    t_wrap = t0_q + n_s;
    s1_d   = s0_q;
    if (s0_q[CALC_W-1]) begin
      s1_d = (mode == MODE_FWD && s_wrap[CALC_W-1]) ? '0 : s_wrap;
    end
    case (mode)
      MODE_FWD: begin
        if (t0_q[CALC_W-1]) begin
          t1_d = t_wrap;
        end else begin
          t1_d = (t0_q > n_s) ? n_s : t0_q;
        end
      end
      MODE_BWD: begin
        if (stop_absent_q) begin
          t1_d = {CALC_W{1'b1}};
        end else if (t0_q[CALC_W-1]) begin
          t1_d = t_wrap[CALC_W-1] ? {CALC_W{1'b1}} : t_wrap;
        end else begin
          t1_d = t0_q;
        end
      end
      default: t1_d = '0;
    endcase
    reps_pos    = !stop_absent_q && (slice_stop_q > $signed(CFG_W'(0)));
    zero_more_d = reps_pos && (slice_stop_q > RunMaxS);
    reps_eff_d  = zero_more_d ? RunMax : slice_stop_q[CNT_W-1:0];
    zero_ok_d   = (s0_q[CALC_W-1] ? !s_wrap[CALC_W-1] : (s0_q < n_s)) && reps_pos;
  end

  // Check the first index and the index just past the run limit
  always_comb begin
    probe_d = PROBE_W'(cur_q) + prod_q;
    stop_p  = PROBE_W'(stop_q);
    case (mode)
      MODE_FWD: begin
        first_ok_d = cur_q < stop_q;
        more_d     = probe_q < stop_p;
      end
      MODE_BWD: begin
        first_ok_d = cur_q > stop_q;
        more_d     = probe_q > stop_p;
      end
      default: begin
        first_ok_d = zero_ok_q;
        more_d     = zero_more_q;
      end
    endcase
  end

  // Step the walk and find the final index of the group
  always_comb begin
    nxt     = cur_q + step_c;
    next_ok = (mode == MODE_FWD) ? (nxt < stop_q) : (nxt > stop_q);
    if (run_cnt_q == RunLastIdx) begin
      last_w = 1'b1;
    end else if (mode == MODE_ZERO) begin
      last_w = (run_cnt_q + CNT_W'(1)) == reps_eff_q;
    end else begin
      last_w = !next_ok;
    end
    slot_free   = !out_valid_q || out_ready_i;
    idx_count_d = idx_count_q + COUNT_W'(1);
  end

  // Setup and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      begin_q <= bm;
      n_q     <= n_d;
    end
    if (cmd_i.sel) begin
      s0_q   <= s0_d;
      t0_q   <= t0_d;
      prod_q <= prod_d;
    end
    if (cmd_i.adj) begin
      s1_q        <= s1_d;
      t1_q        <= t1_d;
      zero_ok_q   <= zero_ok_d;
      zero_more_q <= zero_more_d;
      reps_eff_q  <= reps_eff_d;
    end
    if (cmd_i.base) begin
      cur_q  <= s1_q + begin_s;
      stop_q <= t1_q + begin_s;
    end else if (cmd_i.emit) begin
      cur_q  <= nxt;
    end
    if (cmd_i.probe) begin
      probe_q    <= probe_d;
      first_ok_q <= first_ok_d;
    end
    if (cmd_i.check) begin
      more_q <= more_d;
    end
  end

  // Run counter and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q   <= '0;
      idx_count_q <= '0;
      nonempty_q  <= '0;
    end else begin
      if (cmd_i.base) begin
        run_cnt_q <= '0;
      end else if (cmd_i.emit) begin
        run_cnt_q <= run_cnt_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        idx_count_q <= idx_count_d;
        if (last_w) nonempty_q <= nonempty_q + COUNT_W'(1);
      end
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      row_index_q     <= cur_q[ROW_W-1:0] & RowMask;
      emitted_total_q <= idx_count_d[ROW_W-1:0];
      group_ordinal_q <= nonempty_q[ROW_W-1:0];
      last_q          <= last_w;
      truncated_q     <= more_q;
    end
  end

  assign status_o.first_ok  = first_ok_q;
  assign status_o.last      = last_w;
  assign status_o.slot_free = slot_free;

  assign out_valid_o     = out_valid_q;
  assign row_index_o     = row_index_q;
  assign emitted_total_o = emitted_total_q;
  assign group_ordinal_o = group_ordinal_q;
  assign last_o          = last_q;
  assign truncated_o     = truncated_q;

  `ASSERT_NEVER(a_run_over, cmd_i.emit && (run_cnt_q >= RunMax), "walk ran past the run limit")
  `ASSERT_CLK(a_trunc_full, cmd_i.emit && last_w && more_q |-> run_cnt_q == RunLastIdx, "truncated run ended early")
  `ASSERT_CLK(a_emit_in_bounds, cmd_i.emit && (mode != MODE_ZERO) |-> (mode == MODE_FWD && cur_q < stop_q) || (mode == MODE_BWD && cur_q > stop_q), "index outside slice bounds")

endmodule

`default_nettype wire

FILE: hdl/grouped_slice_row_index_generator.sv
// Grouped slice row index generator: applies one (start, stop, step) slice to each row group.
// Input channel in_chan carries a group's begin and end row offsets; output channel
// out_chan carries one transfer per selected row index, in walk order, with the running
// index count, the count of nonempty groups before this one, a last flag on the
// group's final index and a truncated flag when the run was cut at MAX_RUN indices.
// The slice itself sits in six registers written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write them only while the block is idle, and the block
// itself does not enforce this. A group is taken in the idle state, then the setup
// states SEL, ADJ, BASE, PROBE and CHECK work out its bounds and the truncation probe;
// after that the walk adder emits one index per cycle while the output register is
// free or being read. An empty group returns to idle after CHECK. One group is
// processed at a time.
// Reset clears the walk controller, the running counters, the output valid flag and
// sets the slice registers to start absent, stop absent, step one, zero total rows.
// When the receiver stalls, the output register holds its result and the walk
// pauses; a new group is accepted once the previous group's last index is loaded
// into the output register, even while that index still waits.
`default_nettype none

module grouped_slice_row_index_generator
  import gsri_pkg::*;
#(
  parameter int unsigned MAX_RUN  = 64,
  parameter int unsigned ROW_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  gsri_in_if.sink                   in_chan,
  gsri_out_if.source                out_chan,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  gsri_cmd_t    cmd;
  gsri_status_t status;

  // Sequence setup and walk
  gsri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Compute bounds and produce indices
  gsri_datapath #(
    .MAX_RUN  (MAX_RUN),
    .ROW_BITS (ROW_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .group_begin_i   (in_chan.group_begin),
    .group_end_i     (in_chan.group_end),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_chan.ready),
    .out_valid_o     (out_chan.valid),
    .row_index_o     (out_chan.row_index),
    .emitted_total_o (out_chan.emitted_total),
    .group_ordinal_o (out_chan.group_ordinal),
    .last_o          (out_chan.last),
    .truncated_o     (out_chan.truncated)
  );

endmodule

`default_nettype wire
